// ----- sv/gha_pkg.sv -----
// shared types and defaults for the grouped handle allocator
package gha_pkg;

  localparam int GroupsDef = 16;
  localparam int HandlesPerGroupDef = 256;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_GET   = 2'd2,
    ACT_SET   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_ZERO     = 3'd1,
    STS_RANGE    = 3'd2,
    STS_INACTIVE = 3'd3,
    STS_FREED    = 3'd4,
    STS_CORRUPT  = 3'd5,
    STS_NONE     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_ACC,
    S_UPD,
    S_SCAN,
    S_SETUP,
    S_GRP,
    S_POP,
    S_DONE
  } state_e;

endpackage

// ----- sv/grouped_handle_allocator_core.sv -----
// grouped handle allocator: top level with entry and group memories and the sequencer
// One request at a time. A free, get or set with a zero or out-of-range handle goes
// straight to the result. Otherwise the group and local index come from a two-step
// reciprocal multiply; a set, or any request on an inactive group, then finishes, and a
// get or free does one read-modify-write of the entry and group memories first. An
// allocate scans the groups in order, and a group that is set up on the way gets one
// entry memory write per cycle. The result sits in an output register; the next request
// is taken once it has been loaded there, so a stall on out_stall_i holds it back.
module grouped_handle_allocator_core import gha_pkg::*; #(
  parameter int GROUPS = GroupsDef,
  parameter int HANDLES_PER_GROUP = HandlesPerGroupDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] handle_in_i,
  input  logic [15:0] page_in_i,
  input  logic [15:0] offset_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] handle_out_o,
  output logic [15:0] page_out_o,
  output logic [15:0] offset_out_o,
  output logic [2:0]  status_o
);

  localparam int Total = GROUPS * HANDLES_PER_GROUP;
  localparam int AW = $clog2(Total);
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LW = $clog2(HANDLES_PER_GROUP);

  state_e state_q, state_d;

  logic [4:0]   min_q;
  logic [GROUPS-1:0] active_q;
  action_e      act_q;
  logic [15:0]  hdl_q, pin_q, oin_q;
  logic [GW-1:0] g_q, g_d;
  logic [AW-1:0] base_q, base_d, idx_q;
  logic [LW-1:0] loc_q, loc_d, j_q, j_d;
  logic [12:0]  rh_q, rh_d;
  logic [15:0]  rp_q, rp_d, ro_q, ro_d;
  status_e      rs_q, rs_d;
  logic         out_valid_q;
  logic [12:0]  oh_q;
  logic [15:0]  op_q, oo_q;
  logic [2:0]   os_q;

  // entry memory {page, link} and group memory {head, free count}
  logic [31:0]  ent_mem [Total];
  logic [31:0]  grp_mem [GROUPS];
  logic [31:0]  ent_rd_q, grp_rd_q;
  logic         ent_re, ent_we, grp_re, grp_we;
  logic [AW-1:0] ent_ra, ent_wa;
  logic [31:0]  ent_wd, grp_wd;
  logic         act_set, act_clr;

  logic [15:0]  z;
  logic         div_go_q, div_done;
  logic [GW-1:0] div_q;
  logic [LW-1:0] div_r;
  logic         slot_free, last_grp, acc;
  logic [15:0]  head, cnt, cnt_inc;
  logic [AW:0]  hsum;

  assign z         = handle_in_i - 16'd1;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_grp  = g_q == GW'(GROUPS - 1);
  assign acc       = in_valid_i && !in_stall_o;
  assign head      = grp_rd_q[31:16];
  assign cnt       = grp_rd_q[15:0];
  assign cnt_inc   = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
  assign hsum      = {1'b0, base_q} + (AW + 1)'(loc_q) + (AW + 1)'(1);
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  gha_div #(
    .GROUPS(GROUPS),
    .HANDLES_PER_GROUP(HANDLES_PER_GROUP)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (16'(idx_q)),
    .done_o  (div_done),
    .quot_o  (div_q),
    .rem_o   (div_r)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (action_e'(action_i) == ACT_ALLOC) begin
            state_d = S_SCAN;
          end else if (handle_in_i == '0 || 17'(z) >= 17'(Total)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV:   if (div_done) state_d = S_ACC;
      S_ACC: begin
        if (!active_q[g_q] || act_q == ACT_SET) state_d = S_DONE;
        else state_d = S_UPD;
      end
      S_UPD:   state_d = S_DONE;
      S_SCAN:  state_d = active_q[g_q] ? S_GRP : S_SETUP;
      S_SETUP: if (j_q == LW'(HANDLES_PER_GROUP - 1)) state_d = S_SCAN;
      S_GRP: begin
        if (head == '0 && !last_grp) state_d = S_SCAN;
        else if (head == '0 || head > 16'(HANDLES_PER_GROUP)) state_d = S_DONE;
        else state_d = S_POP;
      end
      S_POP:   state_d = S_DONE;
      S_DONE:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    g_d = g_q;
    base_d = base_q;
    loc_d = loc_q;
    j_d = j_q;
    rh_d = rh_q;
    rp_d = rp_q;
    ro_d = ro_q;
    rs_d = rs_q;
    ent_re = 1'b0;
    ent_we = 1'b0;
    ent_ra = idx_q;
    ent_wa = idx_q;
    ent_wd = {pin_q, oin_q};
    grp_re = 1'b0;
    grp_we = 1'b0;
    grp_wd = '0;
    act_set = 1'b0;
    act_clr = 1'b0;
    case (state_q)
      S_IDLE: begin
        g_d = '0;
        base_d = '0;
        rh_d = '0;
        rp_d = '0;
        ro_d = '0;
        rs_d = STS_OK;
        if (handle_in_i == '0) rs_d = STS_ZERO;
        else rs_d = STS_RANGE;
      end
      S_DIV: begin
        g_d = div_q;
        loc_d = div_r;
      end
      S_ACC: begin
        if (!active_q[g_q]) begin
          rs_d = STS_INACTIVE;
        end else if (act_q == ACT_SET) begin
          ent_we = 1'b1;
          rh_d = hdl_q[12:0];
          rs_d = STS_OK;
        end else begin
          ent_re = 1'b1;
          grp_re = 1'b1;
        end
      end
      S_UPD: begin
        if (act_q == ACT_GET) begin
          rh_d = hdl_q[12:0];
          rp_d = ent_rd_q[31:16];
          ro_d = ent_rd_q[15:0];
          rs_d = STS_OK;
        end else if (ent_rd_q[31:16] == '0) begin
          rs_d = STS_FREED;
        end else begin
          ent_we = 1'b1;
          ent_wd = {16'd0, head};
          if (cnt_inc >= 16'(HANDLES_PER_GROUP) && 7'(g_q) >= 7'(min_q)) begin
            act_clr = 1'b1;
          end else begin
            grp_we = 1'b1;
            grp_wd = {16'(loc_q) + 16'd1, cnt_inc};
          end
          rh_d = hdl_q[12:0];
          rs_d = STS_OK;
        end
      end
      S_SCAN: begin
        j_d = '0;
        grp_re = active_q[g_q];
      end
      S_SETUP: begin
        ent_we = 1'b1;
        ent_wa = base_q + AW'(j_q);
        j_d = j_q + LW'(1);
        if (j_q == LW'(HANDLES_PER_GROUP - 1)) begin
          ent_wd = '0;
          grp_we = 1'b1;
          grp_wd = {16'd1, 16'(HANDLES_PER_GROUP)};
          act_set = 1'b1;
        end else begin
          ent_wd = {16'd0, 16'(j_q) + 16'd2};
        end
      end
      S_GRP: begin
        loc_d = LW'(head - 16'd1);
        if (head == '0) begin
          rs_d = STS_NONE;
          g_d = g_q + GW'(1);
          base_d = base_q + AW'(HANDLES_PER_GROUP);
        end else if (head > 16'(HANDLES_PER_GROUP)) begin
          rs_d = STS_CORRUPT;
        end else begin
          ent_re = 1'b1;
          ent_ra = base_q + AW'(head - 16'd1);
        end
      end
      S_POP: begin
        if (ent_rd_q[31:16] != '0) begin
          rs_d = STS_CORRUPT;
        end else begin
          grp_we = 1'b1;
          grp_wd = {ent_rd_q[15:0], (cnt == '0) ? cnt : cnt - 16'd1};
          rh_d = 13'(hsum);
          rs_d = STS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // the splitter starts in the cycle after the request is taken, from the stored index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      div_go_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= state_q == S_IDLE && state_d == S_DIV;
      if (cfg_valid_i) min_q <= cfg_data_i;
      if (act_set) active_q[g_q] <= 1'b1;
      if (act_clr) active_q[g_q] <= 1'b0;
      if (state_q == S_DONE && slot_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q    <= g_d;
    base_q <= base_d;
    loc_q  <= loc_d;
    j_q    <= j_d;
    rh_q   <= rh_d;
    rp_q   <= rp_d;
    ro_q   <= ro_d;
    rs_q   <= rs_d;
    if (acc) begin
      act_q <= action_e'(action_i);
      hdl_q <= handle_in_i;
      pin_q <= page_in_i;
      oin_q <= offset_in_i;
      idx_q <= AW'(z);
    end
    if (state_q == S_DONE && slot_free) begin
      oh_q <= rh_q;
      op_q <= rp_q;
      oo_q <= ro_q;
      os_q <= rs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd_q <= ent_mem[ent_ra];
    if (grp_we) grp_mem[g_q] <= grp_wd;
    if (grp_re) grp_rd_q <= grp_mem[g_q];
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = oh_q;
  assign page_out_o   = op_q;
  assign offset_out_o = oo_q;
  assign status_o     = os_q;

endmodule

// ----- sv/gha_div.sv -----
// reciprocal-multiply splitter that turns an entry index into group and local index
module gha_div import gha_pkg::*; #(
  parameter int GROUPS = GroupsDef,
  parameter int HANDLES_PER_GROUP = HandlesPerGroupDef,
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1,
  localparam int LW = $clog2(HANDLES_PER_GROUP),
  localparam int Shift = 16 + LW,
  localparam longint unsigned Recip =
    ((64'd1 << Shift) + 64'(HANDLES_PER_GROUP) - 64'd1) / 64'(HANDLES_PER_GROUP)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [15:0]   num_i,
  output logic          done_o,
  output logic [GW-1:0] quot_o,
  output logic [LW-1:0] rem_o
);

  logic          step_q, done_q;
  logic [15:0]   num_q;
  logic [GW-1:0] quot_q;
  logic [LW-1:0] rem_q;
  logic [16:0]   recip;
  logic [32:0]   prod;
  logic [15:0]   back;

  // quotient is exact for any 16-bit index with this shift
  assign recip = 17'(Recip);
  assign prod  = 33'(num_i) * 33'(recip);
  assign back  = 16'(quot_q) * 16'(HANDLES_PER_GROUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= start_i;
      done_q <= step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      quot_q <= prod[Shift +: GW];
    end
    if (step_q) begin
      rem_q <= LW'(num_q - back);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- tb/gha_checker.sv -----
// checker for the grouped handle allocator: predicts each request's result and compares
module gha_checker import gha_pkg::*; #(
  parameter int GROUPS = GroupsDef,
  parameter int HANDLES_PER_GROUP = HandlesPerGroupDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] handle_in_i,
  input  logic [15:0] page_in_i,
  input  logic [15:0] offset_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [12:0] handle_out_i,
  input  logic [15:0] page_out_i,
  input  logic [15:0] offset_out_i,
  input  logic [2:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int Total = GROUPS * HANDLES_PER_GROUP;

  typedef struct packed {
    logic [12:0] handle;
    logic [15:0] page;
    logic [15:0] offset;
    status_e     status;
  } alloc_result_t;

  logic [15:0] page_mem [Total];
  logic [15:0] link_mem [Total];
  int unsigned head_q [GROUPS];
  int unsigned free_cnt [GROUPS];
  bit          active_q [GROUPS];
  int unsigned keep_min;
  alloc_result_t result_q [$];

  assign pending_o = result_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  function automatic alloc_result_t mk(int h, int pg, int of, status_e st);
    alloc_result_t r;
    r.handle = h[12:0];
    r.page = pg[15:0];
    r.offset = of[15:0];
    r.status = st;
    return r;
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] act, int unsigned h,
                                                    logic [15:0] pg, logic [15:0] of);
    int unsigned g, base, loc, z, idx;
    if (act == ACT_ALLOC) begin
      for (g = 0; g < GROUPS; g++) begin
        base = g * HANDLES_PER_GROUP;
        if (!active_q[g]) begin
          for (int j = 0; j < HANDLES_PER_GROUP; j++) begin
            page_mem[base + j] = '0;
            link_mem[base + j] = (j == HANDLES_PER_GROUP - 1) ? 16'd0 : 16'(j + 2);
          end
          head_q[g] = 1;
          free_cnt[g] = HANDLES_PER_GROUP;
          active_q[g] = 1;
        end
        if (head_q[g] == 0) continue;
        if (head_q[g] > HANDLES_PER_GROUP) return mk(0, 0, 0, STS_CORRUPT);
        loc = head_q[g] - 1;
        if (page_mem[base + loc] != 0) return mk(0, 0, 0, STS_CORRUPT);
        head_q[g] = link_mem[base + loc];
        if (free_cnt[g] > 0) free_cnt[g]--;
        return mk(base + loc + 1, 0, 0, STS_OK);
      end
      return mk(0, 0, 0, STS_NONE);
    end
    if (h == 0) return mk(0, 0, 0, STS_ZERO);
    z = h - 1;
    g = z / HANDLES_PER_GROUP;
    if (g >= GROUPS) return mk(0, 0, 0, STS_RANGE);
    if (!active_q[g]) return mk(0, 0, 0, STS_INACTIVE);
    idx = z;
    case (act)
      ACT_FREE: begin
        if (page_mem[idx] == 0) return mk(0, 0, 0, STS_FREED);
        page_mem[idx] = '0;
        link_mem[idx] = 16'(head_q[g]);
        head_q[g] = (idx % HANDLES_PER_GROUP) + 1;
        if (free_cnt[g] < 16'hFFFF) free_cnt[g]++;
        if (free_cnt[g] >= HANDLES_PER_GROUP && g >= keep_min) begin
          active_q[g] = 0;
          head_q[g] = 0;
          free_cnt[g] = 0;
        end
        return mk(h, 0, 0, STS_OK);
      end
      ACT_GET: return mk(h, page_mem[idx], link_mem[idx], STS_OK);
      default: begin
        page_mem[idx] = pg;
        link_mem[idx] = of;
        return mk(h, 0, 0, STS_OK);
      end
    endcase
  endfunction

  initial begin
    fail_count_o = 0;
    keep_min = 0;
    for (int g = 0; g < GROUPS; g++) begin
      head_q[g] = 0;
      free_cnt[g] = 0;
      active_q[g] = 0;
    end
  end

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) keep_min = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        result_q.push_back(predict_request(action_i, handle_in_i, page_in_i, offset_in_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result handle", handle_out_i, 0);
        end else begin
          want = result_q.pop_front();
          if (handle_out_i !== want.handle) report_mismatch("handle", handle_out_i, want.handle);
          if (page_out_i !== want.page) report_mismatch("page", page_out_i, want.page);
          if (offset_out_i !== want.offset) report_mismatch("offset", offset_out_i, want.offset);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// testbench top for the grouped handle allocator: stimulus, clock, reset and verdict
module tb;
  import gha_pkg::*;

  localparam int Groups = GroupsDef;
  localparam int Hpg = HandlesPerGroupDef;
  localparam longint CycleLimit = 20000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  action = ACT_ALLOC;
  logic [15:0] handle_in = '0;
  logic [15:0] page_in = '0;
  logic [15:0] offset_in = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [12:0] handle_out;
  logic [15:0] page_out;
  logic [15:0] offset_out;
  logic [2:0]  status;
  int          fail_count;
  int          pending;
  longint      cycles = 0;
  bit          quiet_rx = 0;
  int unsigned live_q [$];

  always #5 clk = ~clk;

  grouped_handle_allocator_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .action_i(action),
    .handle_in_i(handle_in), .page_in_i(page_in), .offset_in_i(offset_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .handle_out_o(handle_out),
    .page_out_o(page_out), .offset_out_o(offset_out), .status_o(status)
  );

  gha_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .action_i(action),
    .handle_in_i(handle_in), .page_in_i(page_in), .offset_in_i(offset_in),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .handle_out_i(handle_out),
    .page_out_i(page_out), .offset_out_i(offset_out), .status_i(status),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall per result, with quiet stretches
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (out_valid && !out_stall) begin
        @(posedge clk);
        @(negedge clk);
        n = quiet_rx ? 0 : $urandom_range(0, 12);
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(negedge clk);
          out_stall <= 0;
        end
      end else if (!out_valid && !quiet_rx && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // valid stays high into the next request when there is no gap
  task automatic send_request(logic [1:0] act, logic [15:0] h, logic [15:0] pg,
                              logic [15:0] of, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    action <= act;
    handle_in <= h;
    page_in <= pg;
    offset_in <= of;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_keep_min(logic [4:0] v);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // pick a handle that is likely in use, else a random one
  function automatic logic [15:0] pick_handle();
    if (live_q.size() > 0 && $urandom_range(0, 9) < 8)
      return 16'(live_q[$urandom_range(0, live_q.size() - 1)]);
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(1, Groups * Hpg));
    return 16'($urandom);
  endfunction

  initial begin
    int idx;
    logic [15:0] h;
    logic [1:0] act;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    write_keep_min(5'd0);

    // directed: error codes, extremes, every action
    send_request(ACT_FREE, 16'd0, 16'hFFFF, 16'hFFFF, 0);
    send_request(ACT_GET, 16'hFFFF, 16'd0, 16'd0, 0);
    send_request(ACT_GET, 16'd4097, 16'd0, 16'd0, 0);
    send_request(ACT_GET, 16'd1, 16'd0, 16'd0, 0);
    send_request(ACT_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_request(ACT_GET, 16'd1, 16'd0, 16'd0, 0);
    send_request(ACT_GET, 16'd256, 16'd0, 16'd0, 0);
    send_request(ACT_FREE, 16'd2, 16'd0, 16'd0, 0);
    send_request(ACT_SET, 16'd1, 16'hFFFF, 16'hFFFF, 0);
    send_request(ACT_GET, 16'd1, 16'd0, 16'd0, 0);
    send_request(ACT_FREE, 16'd1, 16'd0, 16'd0, 0);
    // head out of range via a set link
    send_request(ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0);
    send_request(ACT_SET, 16'd1, 16'd0, 16'd0, 0);
    send_request(ACT_SET, 16'd2, 16'd0, 16'd300, 0);
    send_request(ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0);
    send_request(ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0);
    // more sets and allocates while the head stays out of range
    send_request(ACT_SET, 16'd2, 16'd0, 16'd3, 0);
    send_request(ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0);
    send_request(ACT_SET, 16'd3, 16'd7, 16'd0, 0);
    send_request(ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0);
    // clear entry 3, allocate twice while the head is still out of range, get the last handle
    send_request(ACT_SET, 16'd3, 16'd0, 16'd0, 0);
    send_request(ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0);
    send_request(ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0);
    send_request(ACT_GET, 16'd4096, 16'd0, 16'd0, 0);

    // random phases: allocate, set mostly nonzero pages, free, get; release follows keep_min
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_keep_min(5'd16);
        1: write_keep_min(5'd0);
        2: write_keep_min(5'd31);
        default: write_keep_min(5'($urandom_range(1, 15)));
      endcase
      quiet_rx = (ph == 2);
      for (int i = 0; i < 320; i++) begin
        idx = $urandom_range(0, 99);
        if (idx < 35) begin
          act = ACT_ALLOC;
          h = 16'($urandom);
        end else if (idx < 60) begin
          act = ACT_SET;
          h = pick_handle();
        end else if (idx < 85) begin
          act = ACT_FREE;
          h = pick_handle();
        end else begin
          act = ACT_GET;
          h = pick_handle();
        end
        send_request(act, h, ($urandom_range(0, 9) == 0) ? 16'd0 :
                     (($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 255))),
                     ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 256)),
                     (ph == 2 && i < 40));
        // track handles that may be live; the checker knows the truth
        if (act == ACT_ALLOC) live_q.push_back($urandom_range(1, 512));
        if (live_q.size() > 64) void'(live_q.pop_front());
        if (act == ACT_ALLOC && $urandom_range(0, 1) == 0)
          for (int k = 0; k < 4; k++) live_q.push_back(k + 1 + 256 * $urandom_range(0, 2));
      end
    end

    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gha_pkg.sv
sv/gha_div.sv
sv/grouped_handle_allocator_core.sv
tb/gha_checker.sv
tb/tb.sv
